FILE: hw/rtl/qpw_pkg.sv
// ----------------------------------------------------------------------------
// qpw_pkg
// Shared widths, register indexes and types of the quadratic coordinate warp.
// ----------------------------------------------------------------------------
package qpw_pkg;

  localparam int COORD_BITS = 12;
  localparam int BW         = 16;
  localparam int UW         = ((COORD_BITS > BW) ? COORD_BITS : BW) + 2;
  localparam int PW         = 2 * UW;
  localparam int CW         = 32;
  localparam int LPW        = CW + UW;
  localparam int QPW        = CW + PW;
  localparam int ACCW       = QPW + 3;
  localparam int C0_SHIFT   = 34;
  localparam int LIN_SHIFT  = 16;
  localparam int FRAC_SHIFT = 34;
  localparam int QW         = ACCW - FRAC_SHIFT;
  localparam int OW         = 28;
  localparam int FRAC_OUT   = 12;
  localparam int DW         = 64;
  localparam int OFSW       = 32;
  localparam int CIW        = 3;

  localparam logic signed [QW-1:0] Q_MAX = QW'((2 ** (OW - 1)) - 1);
  localparam logic signed [QW-1:0] Q_MIN = QW'(-(2 ** (OW - 1)));

  localparam logic [CIW-1:0] REG_CONSTANT      = 3'd0;
  localparam logic [CIW-1:0] REG_LINEAR_FIRST  = 3'd1;
  localparam logic [CIW-1:0] REG_LINEAR_SECOND = 3'd2;
  localparam logic [CIW-1:0] REG_SQUARE_FIRST  = 3'd3;
  localparam logic [CIW-1:0] REG_CROSS_TERM    = 3'd4;
  localparam logic [CIW-1:0] REG_SQUARE_SECOND = 3'd5;
  localparam logic [CIW-1:0] REG_OFFSETS       = 3'd6;
  localparam logic [CIW-1:0] REG_BOUNDS        = 3'd7;

  typedef struct packed {
    logic signed [CW-1:0] c0;
    logic signed [CW-1:0] c1;
    logic signed [CW-1:0] c2;
    logic signed [CW-1:0] c3;
    logic signed [CW-1:0] c4;
    logic signed [CW-1:0] c5;
  } coef_t;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } adv_t;

endpackage

FILE: hw/rtl/qpw_cfg.sv
// ----------------------------------------------------------------------------
// qpw_cfg
// Configuration register file; splits packed coefficients per axis.
// ----------------------------------------------------------------------------
module qpw_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic [qpw_pkg::CIW-1:0]      cfg_index,
  input  logic [qpw_pkg::DW-1:0]       cfg_data,
  output qpw_pkg::coef_t               coef_first,
  output qpw_pkg::coef_t               coef_second,
  output logic [qpw_pkg::OFSW-1:0]     offsets,
  output logic [qpw_pkg::DW-1:0]       bounds
);

  logic [qpw_pkg::DW-1:0]   c0_r, c1_r, c2_r, c3_r, c4_r, c5_r;
  logic [qpw_pkg::OFSW-1:0] ofs_r;
  logic [qpw_pkg::DW-1:0]   bnd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r  <= '0;
      c1_r  <= '0;
      c2_r  <= '0;
      c3_r  <= '0;
      c4_r  <= '0;
      c5_r  <= '0;
      ofs_r <= '0;
      bnd_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        qpw_pkg::REG_CONSTANT:      c0_r  <= cfg_data;
        qpw_pkg::REG_LINEAR_FIRST:  c1_r  <= cfg_data;
        qpw_pkg::REG_LINEAR_SECOND: c2_r  <= cfg_data;
        qpw_pkg::REG_SQUARE_FIRST:  c3_r  <= cfg_data;
        qpw_pkg::REG_CROSS_TERM:    c4_r  <= cfg_data;
        qpw_pkg::REG_SQUARE_SECOND: c5_r  <= cfg_data;
        qpw_pkg::REG_OFFSETS:       ofs_r <= cfg_data[qpw_pkg::OFSW-1:0];
        qpw_pkg::REG_BOUNDS:        bnd_r <= cfg_data;
      endcase
    end
  end

  assign coef_first.c0  = $signed(c0_r[63:32]);
  assign coef_first.c1  = $signed(c1_r[63:32]);
  assign coef_first.c2  = $signed(c2_r[63:32]);
  assign coef_first.c3  = $signed(c3_r[63:32]);
  assign coef_first.c4  = $signed(c4_r[63:32]);
  assign coef_first.c5  = $signed(c5_r[63:32]);
  assign coef_second.c0 = $signed(c0_r[31:0]);
  assign coef_second.c1 = $signed(c1_r[31:0]);
  assign coef_second.c2 = $signed(c2_r[31:0]);
  assign coef_second.c3 = $signed(c3_r[31:0]);
  assign coef_second.c4 = $signed(c4_r[31:0]);
  assign coef_second.c5 = $signed(c5_r[31:0]);
  assign offsets        = ofs_r;
  assign bounds         = bnd_r;

endmodule

FILE: hw/rtl/qpw_terms.sv
// ----------------------------------------------------------------------------
// qpw_terms
// Stages 1-2: offset coordinates u, v and their second-order monomials.
// ----------------------------------------------------------------------------
module qpw_terms (
  input  logic                              clk,
  input  qpw_pkg::adv_t                     adv,
  input  logic [qpw_pkg::COORD_BITS-1:0]    in_first,
  input  logic [qpw_pkg::COORD_BITS-1:0]    in_second,
  input  logic [qpw_pkg::OFSW-1:0]          offsets,
  output logic signed [qpw_pkg::UW-1:0]     u,
  output logic signed [qpw_pkg::UW-1:0]     v,
  output logic signed [qpw_pkg::PW-1:0]     uu,
  output logic signed [qpw_pkg::PW-1:0]     uv,
  output logic signed [qpw_pkg::PW-1:0]     vv
);

  localparam int ZW = qpw_pkg::UW - qpw_pkg::COORD_BITS;

  logic signed [qpw_pkg::BW-1:0] off_first, off_second;
  logic signed [qpw_pkg::UW-1:0] u1_nxt, v1_nxt;
  logic signed [qpw_pkg::UW-1:0] u1_r, v1_r, u2_r, v2_r;
  logic signed [qpw_pkg::PW-1:0] uu_nxt, uv_nxt, vv_nxt;
  logic signed [qpw_pkg::PW-1:0] uu_r, uv_r, vv_r;

  assign off_first  = $signed(offsets[31:16]);
  assign off_second = $signed(offsets[15:0]);

  assign u1_nxt = $signed({{ZW{1'b0}}, in_first}) + qpw_pkg::UW'(off_first);
  assign v1_nxt = $signed({{ZW{1'b0}}, in_second}) + qpw_pkg::UW'(off_second);

  assign uu_nxt = u1_r * u1_r;
  assign uv_nxt = u1_r * v1_r;
  assign vv_nxt = v1_r * v1_r;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      u1_r <= u1_nxt;
      v1_r <= v1_nxt;
    end
    if (adv.s2) begin
      u2_r <= u1_r;
      v2_r <= v1_r;
      uu_r <= uu_nxt;
      uv_r <= uv_nxt;
      vv_r <= vv_nxt;
    end
  end

  assign u  = u2_r;
  assign v  = v2_r;
  assign uu = uu_r;
  assign uv = uv_r;
  assign vv = vv_r;

endmodule

FILE: hw/rtl/qpw_axis.sv
// ----------------------------------------------------------------------------
// qpw_axis
// Stages 3-5 of one axis: coefficient products, partial sums, round and
// saturate to signed Q16.12.
// ----------------------------------------------------------------------------
module qpw_axis (
  input  logic                           clk,
  input  qpw_pkg::adv_t                  adv,
  input  qpw_pkg::coef_t                 coef,
  input  logic signed [qpw_pkg::UW-1:0]  u,
  input  logic signed [qpw_pkg::UW-1:0]  v,
  input  logic signed [qpw_pkg::PW-1:0]  uu,
  input  logic signed [qpw_pkg::PW-1:0]  uv,
  input  logic signed [qpw_pkg::PW-1:0]  vv,
  output logic signed [qpw_pkg::OW-1:0]  src
);

  logic signed [qpw_pkg::LPW-1:0]  p1_nxt, p2_nxt, p1_r, p2_r;
  logic signed [qpw_pkg::QPW-1:0]  p3_nxt, p4_nxt, p5_nxt, p3_r, p4_r, p5_r;
  logic signed [qpw_pkg::ACCW-1:0] lin_nxt, quad_nxt, lin_r, quad_r, sum;
  logic signed [qpw_pkg::QW-1:0]   q;
  logic signed [qpw_pkg::OW-1:0]   src_nxt, src_r;

  assign p1_nxt = coef.c1 * u;
  assign p2_nxt = coef.c2 * v;
  assign p3_nxt = coef.c3 * uu;
  assign p4_nxt = coef.c4 * uv;
  assign p5_nxt = coef.c5 * vv;

  // half-LSB rounding constant folded into the linear partial sum
  assign lin_nxt  = (qpw_pkg::ACCW'(coef.c0) <<< qpw_pkg::C0_SHIFT)
                  + (qpw_pkg::ACCW'(p1_r) <<< qpw_pkg::LIN_SHIFT)
                  + (qpw_pkg::ACCW'(p2_r) <<< qpw_pkg::LIN_SHIFT)
                  + (qpw_pkg::ACCW'(1) <<< (qpw_pkg::FRAC_SHIFT - 1));
  assign quad_nxt = qpw_pkg::ACCW'(p3_r) + qpw_pkg::ACCW'(p4_r) + qpw_pkg::ACCW'(p5_r);

  assign sum = lin_r + quad_r;
  assign q   = $signed(sum[qpw_pkg::ACCW-1:qpw_pkg::FRAC_SHIFT]);

  always_comb begin
    priority if (q > qpw_pkg::Q_MAX) begin
      src_nxt = qpw_pkg::OW'(qpw_pkg::Q_MAX);
    end else if (q < qpw_pkg::Q_MIN) begin
      src_nxt = qpw_pkg::OW'(qpw_pkg::Q_MIN);
    end else begin
      src_nxt = qpw_pkg::OW'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      p3_r <= p3_nxt;
      p4_r <= p4_nxt;
      p5_r <= p5_nxt;
    end
    if (adv.s4) begin
      lin_r  <= lin_nxt;
      quad_r <= quad_nxt;
    end
    if (adv.s5) begin
      src_r <= src_nxt;
    end
  end

  assign src = src_r;

endmodule

FILE: hw/rtl/quadratic_polynomial_coordinate_warp_top.sv
// ----------------------------------------------------------------------------
// quadratic_polynomial_coordinate_warp_top
// Second-order polynomial inverse coordinate warp with bounds flag.
// Pipeline: six register stages from input request to output valid.
// Throughput: one request per cycle unless the output stalls, set by the stage
// pipeline; stalls back up stage by stage without loss.
// Reset: synchronous active-low rst_n clears valid bits and all config regs.
// ----------------------------------------------------------------------------
module quadratic_polynomial_coordinate_warp_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [qpw_pkg::COORD_BITS-1:0]       in_out_first,
  input  logic [qpw_pkg::COORD_BITS-1:0]       in_out_second,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [qpw_pkg::OW-1:0]        out_src_first,
  output logic signed [qpw_pkg::OW-1:0]        out_src_second,
  output logic                                 out_inside_source,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [qpw_pkg::CIW-1:0]              cfg_index,
  input  logic [qpw_pkg::DW-1:0]               cfg_data
);

  qpw_pkg::coef_t                 coef_first, coef_second;
  logic [qpw_pkg::OFSW-1:0]       offsets;
  logic [qpw_pkg::DW-1:0]         bounds;
  qpw_pkg::adv_t                  adv;
  logic [5:0]                     vld_r, vld_nxt, rdy;
  logic signed [qpw_pkg::UW-1:0]  u, v;
  logic signed [qpw_pkg::PW-1:0]  uu, uv, vv;
  logic signed [qpw_pkg::OW-1:0]  src_first, src_second;
  logic signed [qpw_pkg::OW-1:0]  min_f, max_f, min_s, max_s;
  logic signed [qpw_pkg::OW-1:0]  first_r, second_r;
  logic                           inside_nxt, inside_r;

  assign cfg_ready = 1'b1;

  qpw_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .coef_first  (coef_first),
    .coef_second (coef_second),
    .offsets     (offsets),
    .bounds      (bounds)
  );

  // stage k loads when empty or when stage k+1 moves
  assign rdy[5] = !vld_r[5] || out_ready;
  assign rdy[4] = !vld_r[4] || rdy[5];
  assign rdy[3] = !vld_r[3] || rdy[4];
  assign rdy[2] = !vld_r[2] || rdy[3];
  assign rdy[1] = !vld_r[1] || rdy[2];
  assign rdy[0] = !vld_r[0] || rdy[1];

  assign adv.s1 = rdy[0];
  assign adv.s2 = rdy[1];
  assign adv.s3 = rdy[2];
  assign adv.s4 = rdy[3];
  assign adv.s5 = rdy[4];
  assign adv.s6 = rdy[5];

  assign vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
  assign vld_nxt[1] = rdy[1] ? vld_r[0] : vld_r[1];
  assign vld_nxt[2] = rdy[2] ? vld_r[1] : vld_r[2];
  assign vld_nxt[3] = rdy[3] ? vld_r[2] : vld_r[3];
  assign vld_nxt[4] = rdy[4] ? vld_r[3] : vld_r[4];
  assign vld_nxt[5] = rdy[5] ? vld_r[4] : vld_r[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready = rdy[0];

  qpw_terms u_terms (
    .clk       (clk),
    .adv       (adv),
    .in_first  (in_out_first),
    .in_second (in_out_second),
    .offsets   (offsets),
    .u         (u),
    .v         (v),
    .uu        (uu),
    .uv        (uv),
    .vv        (vv)
  );

  qpw_axis u_axis_first (
    .clk  (clk),
    .adv  (adv),
    .coef (coef_first),
    .u    (u),
    .v    (v),
    .uu   (uu),
    .uv   (uv),
    .vv   (vv),
    .src  (src_first)
  );

  qpw_axis u_axis_second (
    .clk  (clk),
    .adv  (adv),
    .coef (coef_second),
    .u    (u),
    .v    (v),
    .uu   (uu),
    .uv   (uv),
    .vv   (vv),
    .src  (src_second)
  );

  // bounds in integer pixels, scaled to Q12
  assign min_f = $signed({bounds[63:48], {qpw_pkg::FRAC_OUT{1'b0}}});
  assign max_f = $signed({bounds[47:32], {qpw_pkg::FRAC_OUT{1'b0}}});
  assign min_s = $signed({bounds[31:16], {qpw_pkg::FRAC_OUT{1'b0}}});
  assign max_s = $signed({bounds[15:0],  {qpw_pkg::FRAC_OUT{1'b0}}});

  assign inside_nxt = (src_first >= min_f) && (src_first <= max_f) &&
                      (src_second >= min_s) && (src_second <= max_s);

  always_ff @(posedge clk) begin
    if (adv.s6) begin
      first_r  <= src_first;
      second_r <= src_second;
      inside_r <= inside_nxt;
    end
  end

  assign out_valid         = vld_r[5];
  assign out_src_first     = first_r;
  assign out_src_second    = second_r;
  assign out_inside_source = inside_r;

endmodule

FILE: hw/rtl/qpw_checker.sv
// ----------------------------------------------------------------------------
// qpw_checker
// Port-level assertions for the coordinate warp, bound to the top level.
// ----------------------------------------------------------------------------
module qpw_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [qpw_pkg::OW-1:0]       out_src_first,
  input logic signed [qpw_pkg::OW-1:0]       out_src_second,
  input logic                                out_inside_source,
  input logic                                cfg_ready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_src_first) &&
    $stable(out_src_second) && $stable(out_inside_source))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a draining output lets every stage move
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind quadratic_polynomial_coordinate_warp_top qpw_checker u_qpw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_src_first     (out_src_first),
  .out_src_second    (out_src_second),
  .out_inside_source (out_inside_source),
  .cfg_ready         (cfg_ready)
);
